FILE: design/ntpc_pkg.sv
`default_nettype none
package ntpc_pkg;

    localparam int unsigned TS_W      = 32;
    localparam int unsigned OFFSET_W  = 17;
    localparam int unsigned DAY_W     = 16;
    localparam int unsigned YO_W      = 8;
    localparam int unsigned DOY_W     = 9;
    localparam int unsigned LEAPS_W   = 6;
    localparam int unsigned DIVISOR_W = 17;
    localparam int unsigned PHASE_W   = 2;

    localparam logic [TS_W-1:0] SECS_1900_TO_1970 = 32'd2208988800;
    localparam logic [DIVISOR_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [DIVISOR_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [DIVISOR_W-1:0] SECS_PER_MIN  = 17'd60;
    localparam logic [DIVISOR_W-1:0] DAYS_PER_WEEK = 17'd7;
    localparam logic [DIVISOR_W-1:0] DAYS_PER_YEAR = 17'd365;

    // floor(2^32 / divisor): the estimate lands on the quotient or one below it
    localparam logic [TS_W-1:0] RECIP_DAY  = TS_W'(64'd4294967296 / 64'd86400);
    localparam logic [TS_W-1:0] RECIP_HOUR = TS_W'(64'd4294967296 / 64'd3600);
    localparam logic [TS_W-1:0] RECIP_MIN  = TS_W'(64'd4294967296 / 64'd60);
    localparam logic [TS_W-1:0] RECIP_WEEK = TS_W'(64'd4294967296 / 64'd7);
    localparam logic [TS_W-1:0] RECIP_YEAR = TS_W'(64'd4294967296 / 64'd365);

    // Steps of one division on the shared multiplier
    localparam logic [PHASE_W-1:0] PH_EST  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_BACK = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FIX  = 2'd2;

    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
    localparam logic [11:0] SKIPPED_LEAP  = 12'd2100;
    localparam logic [DAY_W-1:0] EPOCH_WDAY = 16'd4;  // 1970-01-01 was a Thursday
    localparam int unsigned MONTH_LAST = 11;

    localparam logic [DOY_W-1:0] CUM_DAYS [2][13] = '{
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
          9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365},
        '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
          9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366}
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_WDAY,
        S_YEAR,
        S_YCHK,
        S_DOY,
        S_MONTH
    } t_state;

    // Leap days from 1970 up to 1970 + yo. Over years 1969..2105 the century
    // terms collapse to a constant, minus one once 2100 is passed.
    function automatic logic [LEAPS_W-1:0] leaps_before(input logic [YO_W-1:0] yo);
        logic [11:0] r;
        logic [11:0] q;
        r = 12'(yo) + 12'd1969;
        q = (r >> 2) - 12'd492 - ((yo >= 8'd131) ? 12'd1 : 12'd0);
        return q[LEAPS_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/ntp_seconds_to_calendar_top.sv
`default_nettype none
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+---------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_timestamp, i_use_local
// out      | output    | o_out_valid / i_out_ready  | o_year .. o_weekday
// cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (time offset, signed)
//
// An item is accepted, then passes the shared multiplier for days, hours,
// minutes, weekday and years, three steps each: reciprocal estimate, back-multiply,
// correction; then year check, day of year and month. The result sits in an
// output register, so the next item may start while it waits; the month step
// holds while that register is still full.
// Reset is synchronous, active low; it clears the offset to zero.
module ntp_seconds_to_calendar_top
    import ntpc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [OFFSET_W-1:0] i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [TS_W-1:0]     i_timestamp,
    input  wire logic                i_use_local,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [11:0]              o_year,
    output logic [3:0]               o_month,
    output logic [4:0]               o_day_of_month,
    output logic [4:0]               o_hour,
    output logic [5:0]               o_minute,
    output logic [5:0]               o_second,
    output logic [2:0]               o_weekday
);

    t_state r_state, n_state;
    logic [OFFSET_W-1:0] r_offset;
    logic [TS_W-1:0]     r_rem, n_rem;
    logic [DAY_W-1:0]    r_quo, n_quo;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [DAY_W-1:0]    r_day, n_day;
    logic [4:0]          r_hour, n_hour;
    logic [5:0]          r_min, n_min;
    logic [5:0]          r_sec, n_sec;
    logic [2:0]          r_wday, n_wday;
    logic [YO_W-1:0]     r_yo, n_yo;
    logic [DOY_W-1:0]    r_doy, n_doy;
    logic                r_leap, n_leap;
    logic                r_out_valid, n_out_valid;
    logic [11:0]         r_o_year, n_o_year;
    logic [3:0]          r_o_month, n_o_month;
    logic [4:0]          r_o_dom, n_o_dom;
    logic [4:0]          r_o_hour, n_o_hour;
    logic [5:0]          r_o_min, n_o_min;
    logic [5:0]          r_o_sec, n_o_sec;
    logic [2:0]          r_o_wday, n_o_wday;

    logic [DIVISOR_W-1:0] w_divisor;
    logic [TS_W-1:0]      w_recip;
    logic [TS_W-1:0]      w_mul_a;
    logic [TS_W-1:0]      w_mul_b;
    logic [2*TS_W-1:0]    w_prod;
    logic [DAY_W-1:0]     w_quo_est;
    logic [TS_W-1:0]      w_rem_back;
    logic                 w_fix;
    logic [DAY_W-1:0]     w_quo_fin;
    logic [TS_W-1:0]      w_rem_fin;
    logic [TS_W-1:0]      w_t;
    logic [DAY_W-1:0]     w_start;
    logic [11:0]          w_year;
    logic [3:0]           w_mcnt;

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_year         = r_o_year;
    assign o_month        = r_o_month;
    assign o_day_of_month = r_o_dom;
    assign o_hour         = r_o_hour;
    assign o_minute       = r_o_min;
    assign o_second       = r_o_sec;
    assign o_weekday      = r_o_wday;

    // Shared multiplier: estimate the quotient by reciprocal, multiply it back,
    // then correct once if the remainder is still a divisor or more
    always_comb begin
        case (r_state)
            S_DAY: begin
                w_divisor = SECS_PER_DAY;
                w_recip   = RECIP_DAY;
            end
            S_HOUR: begin
                w_divisor = SECS_PER_HOUR;
                w_recip   = RECIP_HOUR;
            end
            S_MIN: begin
                w_divisor = SECS_PER_MIN;
                w_recip   = RECIP_MIN;
            end
            S_WDAY: begin
                w_divisor = DAYS_PER_WEEK;
                w_recip   = RECIP_WEEK;
            end
            S_YEAR: begin
                w_divisor = DAYS_PER_YEAR;
                w_recip   = RECIP_YEAR;
            end
            default: begin
                w_divisor = SECS_PER_DAY;
                w_recip   = RECIP_DAY;
            end
        endcase
        if (r_phase == PH_EST) begin
            w_mul_a = r_rem;
            w_mul_b = w_recip;
        end else begin
            w_mul_a = TS_W'(r_quo);
            w_mul_b = TS_W'(w_divisor);
        end
        w_prod     = (2*TS_W)'(w_mul_a) * (2*TS_W)'(w_mul_b);
        w_quo_est  = w_prod[TS_W +: DAY_W];
        w_rem_back = r_rem - w_prod[TS_W-1:0];
        w_fix      = (r_rem >= TS_W'(w_divisor));
        w_quo_fin  = r_quo + DAY_W'(w_fix);
        w_rem_fin  = w_fix ? (r_rem - TS_W'(w_divisor)) : r_rem;
    end

    always_comb begin
        w_t = i_timestamp;
        if (i_use_local) begin
            w_t = w_t + {{(TS_W-OFFSET_W){r_offset[OFFSET_W-1]}}, r_offset};
        end
        w_t = w_t - SECS_1900_TO_1970;
    end

    // Start day of year offset r_yo; one multiplier shared by check and day-of-year
    assign w_start = DAY_W'({8'b0, r_yo} * 16'd365) + DAY_W'(leaps_before(r_yo));
    assign w_year  = 12'(r_yo) + EPOCH_YEAR;

    always_comb begin
        w_mcnt = 4'd0;
        for (int m = 1; m <= MONTH_LAST; m++) begin
            if (r_doy >= CUM_DAYS[r_leap][m]) begin
                w_mcnt = w_mcnt + 4'd1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_phase     = r_phase;
        n_day       = r_day;
        n_hour      = r_hour;
        n_min       = r_min;
        n_sec       = r_sec;
        n_wday      = r_wday;
        n_yo        = r_yo;
        n_doy       = r_doy;
        n_leap      = r_leap;
        n_out_valid = r_out_valid;
        n_o_year    = r_o_year;
        n_o_month   = r_o_month;
        n_o_dom     = r_o_dom;
        n_o_hour    = r_o_hour;
        n_o_min     = r_o_min;
        n_o_sec     = r_o_sec;
        n_o_wday    = r_o_wday;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rem   = w_t;
                    n_phase = PH_EST;
                    n_state = S_DAY;
                end
            end
            S_DAY, S_HOUR, S_MIN, S_WDAY, S_YEAR: begin
                case (r_phase)
                    PH_EST: begin
                        n_quo   = w_quo_est;
                        n_phase = PH_BACK;
                    end
                    PH_BACK: begin
                        n_rem   = w_rem_back;
                        n_phase = PH_FIX;
                    end
                    default: begin
                        n_phase = PH_EST;
                        case (r_state)
                            S_DAY: begin
                                n_day   = w_quo_fin;
                                n_rem   = w_rem_fin;
                                n_state = S_HOUR;
                            end
                            S_HOUR: begin
                                n_hour  = w_quo_fin[4:0];
                                n_rem   = w_rem_fin;
                                n_state = S_MIN;
                            end
                            S_MIN: begin
                                n_min   = w_quo_fin[5:0];
                                n_sec   = w_rem_fin[5:0];
                                n_rem   = TS_W'(r_day + EPOCH_WDAY);
                                n_state = S_WDAY;
                            end
                            S_WDAY: begin
                                n_wday  = w_rem_fin[2:0];
                                n_rem   = TS_W'(r_day);
                                n_state = S_YEAR;
                            end
                            default: begin
                                n_yo    = w_quo_fin[YO_W-1:0];
                                n_state = S_YCHK;
                            end
                        endcase
                    end
                endcase
            end
            S_YCHK: begin
                // Estimate overshoots by at most one year
                if (r_day < w_start) begin
                    n_yo = r_yo - 8'd1;
                end
                n_state = S_DOY;
            end
            S_DOY: begin
                n_doy   = DOY_W'(r_day - w_start);
                n_leap  = (w_year[1:0] == 2'b00) && (w_year != SKIPPED_LEAP);
                n_state = S_MONTH;
            end
            S_MONTH: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_year    = w_year;
                    n_o_month   = w_mcnt + 4'd1;
                    n_o_dom     = 5'(r_doy - CUM_DAYS[r_leap][w_mcnt] + 9'd1);
                    n_o_hour    = r_hour;
                    n_o_min     = r_min;
                    n_o_sec     = r_sec;
                    n_o_wday    = r_wday;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_offset    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_offset <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_phase  <= n_phase;
        r_day    <= n_day;
        r_hour   <= n_hour;
        r_min    <= n_min;
        r_sec    <= n_sec;
        r_wday   <= n_wday;
        r_yo     <= n_yo;
        r_doy    <= n_doy;
        r_leap   <= n_leap;
        r_o_year <= n_o_year;
        r_o_month <= n_o_month;
        r_o_dom  <= n_o_dom;
        r_o_hour <= n_o_hour;
        r_o_min  <= n_o_min;
        r_o_sec  <= n_o_sec;
        r_o_wday <= n_o_wday;
    end

endmodule
`default_nettype wire
